FILE: src/clps_pkg.sv
`default_nettype none

package clps_pkg;

  // Coordinate width default and fixed field widths
  localparam int COORD_BITS_DEF = 12;
  localparam int CFG_W          = 12;
  localparam int CFG_IDX_W      = 3;
  localparam int ADDR_W         = 22;
  localparam int COLOR_W        = 16;
  localparam int QUEUE_DEPTH    = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_ENABLE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_SPAN_X   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_SPAN_Y   = 3'd6;

  // Request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  // Register reset values
  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 12'd240;
  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 12'd240;

  typedef struct packed {
    logic [CFG_W-1:0]        screen_width;
    logic [CFG_W-1:0]        screen_height;
    logic                    clip_enable;
    logic signed [CFG_W-1:0] clip_left;
    logic signed [CFG_W-1:0] clip_top;
    logic [CFG_W-1:0]        clip_span_x;
    logic [CFG_W-1:0]        clip_span_y;
  } cfg_t;

endpackage

`default_nettype wire

FILE: src/clps_front.sv
`default_nettype none

module clps_front #(
  parameter int COORD_BITS = clps_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           req_type,
  input  logic [COORD_BITS-1:0]          start_x,
  input  logic [COORD_BITS-1:0]          start_y,
  input  logic [COORD_BITS-1:0]          end_x,
  input  logic [COORD_BITS-1:0]          end_y,
  input  logic [clps_pkg::COLOR_W-1:0]   line_color,
  output logic                           head_valid,
  input  logic                           head_pop,
  output logic                           head_step,
  output logic [COORD_BITS-1:0]          head_x1,
  output logic [COORD_BITS-1:0]          head_y1,
  output logic [COORD_BITS-1:0]          head_x2,
  output logic [COORD_BITS-1:0]          head_y2,
  output logic [clps_pkg::COLOR_W-1:0]   head_color,
  output logic [COORD_BITS-1:0]          head_abs_dx,
  output logic [COORD_BITS:0]            head_neg_abs_dy,
  output logic                           head_step_x_neg,
  output logic                           head_step_y_neg
);
  import clps_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int ENT_W = 1 + 6 * CB + COLOR_W + 1 + 2;
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CB:0]       dx;
  logic [CB:0]       dy;
  logic [CB-1:0]     abs_dx;
  logic [CB-1:0]     abs_dy;
  logic [CB:0]       neg_abs_dy;
  logic              step_x_neg;
  logic              step_y_neg;
  logic [ENT_W-1:0]  ent_in;
  logic [ENT_W-1:0]  entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;

  // Classify the request and work out the stepper setup
  assign dx = {end_x[CB-1], end_x} - {start_x[CB-1], start_x};
  assign dy = {end_y[CB-1], end_y} - {start_y[CB-1], start_y};
  assign abs_dx = dx[CB] ? CB'((CB+1)'(0) - dx) : dx[CB-1:0];
  assign abs_dy = dy[CB] ? CB'((CB+1)'(0) - dy) : dy[CB-1:0];
  assign neg_abs_dy = (CB+1)'(0) - {1'b0, abs_dy};
  assign step_x_neg = dx[CB] || (dx == '0);
  assign step_y_neg = dy[CB] || (dy == '0);

  assign ent_in = {req_type, start_x, start_y, end_x, end_y, line_color,
                   abs_dx, neg_abs_dy, step_x_neg, step_y_neg};

  assign in_ready   = (count != CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign push       = in_valid && in_ready;

  // Present the oldest request
  assign {head_step, head_x1, head_y1, head_x2, head_y2, head_color,
          head_abs_dx, head_neg_abs_dy, head_step_x_neg, head_step_y_neg} = entries[rd_ptr];

  // Store incoming request
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= ent_in;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (head_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !head_pop) begin
        count <= count + CNT_W'(1);
      end else if (head_pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/clps_stepper.sv
`default_nettype none

module clps_stepper #(
  parameter int COORD_BITS = clps_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  clps_pkg::cfg_t                 cfg,
  input  logic                           head_valid,
  output logic                           head_pop,
  input  logic                           head_step,
  input  logic [COORD_BITS-1:0]          head_x1,
  input  logic [COORD_BITS-1:0]          head_y1,
  input  logic [COORD_BITS-1:0]          head_x2,
  input  logic [COORD_BITS-1:0]          head_y2,
  input  logic [clps_pkg::COLOR_W-1:0]   head_color,
  input  logic [COORD_BITS-1:0]          head_abs_dx,
  input  logic [COORD_BITS:0]            head_neg_abs_dy,
  input  logic                           head_step_x_neg,
  input  logic                           head_step_y_neg,
  output logic                           pix_valid,
  input  logic                           pix_ready,
  output logic [COORD_BITS-1:0]          pix_x,
  output logic [COORD_BITS-1:0]          pix_y,
  output logic [clps_pkg::COLOR_W-1:0]   pix_color,
  output logic                           pix_last,
  output logic                           pix_vis
);
  import clps_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int CMP_W = ((CB > CFG_W) ? CB : CFG_W) + 2;

  logic [CB-1:0]      cur_x;
  logic [CB-1:0]      cur_y;
  logic [CB-1:0]      target_x;
  logic [CB-1:0]      target_y;
  logic [CB-1:0]      abs_dx;
  logic [CB:0]        neg_abs_dy;
  logic               step_x_neg;
  logic               step_y_neg;
  logic [CB+1:0]      error_term;
  logic [COLOR_W-1:0] held_color;
  logic               active;

  logic               load;
  logic               emit;
  logic               last;
  logic               move_x;
  logic               move_y;
  logic [CB+1:0]      error_next;
  logic [CB-1:0]      cur_x_next;
  logic [CB-1:0]      cur_y_next;

  logic signed [CMP_W-1:0] xs;
  logic signed [CMP_W-1:0] ys;
  logic signed [CMP_W-1:0] width_s;
  logic signed [CMP_W-1:0] height_s;
  logic signed [CMP_W-1:0] left_s;
  logic signed [CMP_W-1:0] top_s;
  logic signed [CMP_W-1:0] right_s;
  logic signed [CMP_W-1:0] bottom_s;
  logic                    on_screen;
  logic                    in_clip;

  // Take a load or idle step at once; hold a pixel step while the stage is stalled
  assign head_pop = head_valid && (!head_step || !active || !pix_valid || pix_ready);
  assign load     = head_pop && (head_step == REQ_LOAD);
  assign emit     = head_pop && (head_step == REQ_STEP) && active;

  // Check the current pixel against screen and clip rectangle
  assign xs       = CMP_W'($signed(cur_x));
  assign ys       = CMP_W'($signed(cur_y));
  assign width_s  = $signed(CMP_W'(cfg.screen_width));
  assign height_s = $signed(CMP_W'(cfg.screen_height));
  assign left_s   = CMP_W'(cfg.clip_left);
  assign top_s    = CMP_W'(cfg.clip_top);
  assign right_s  = left_s + $signed(CMP_W'(cfg.clip_span_x));
  assign bottom_s = top_s + $signed(CMP_W'(cfg.clip_span_y));
  assign on_screen = (xs >= 0) && (ys >= 0) && (xs < width_s) && (ys < height_s);
  assign in_clip   = (xs >= left_s) && (ys >= top_s) && (xs < right_s) && (ys < bottom_s);

  // One Bresenham update
  assign last   = (cur_x == target_x) && (cur_y == target_y);
  assign move_x = $signed({error_term, 1'b0}) >= $signed({{2{neg_abs_dy[CB]}}, neg_abs_dy});
  assign move_y = $signed({error_term, 1'b0}) <= $signed({3'b000, abs_dx});
  assign error_next = error_term
                    + (move_x ? {neg_abs_dy[CB], neg_abs_dy} : (CB+2)'(0))
                    + (move_y ? {2'b00, abs_dx} : (CB+2)'(0));
  assign cur_x_next = move_x ? (step_x_neg ? cur_x - CB'(1) : cur_x + CB'(1)) : cur_x;
  assign cur_y_next = move_y ? (step_y_neg ? cur_y - CB'(1) : cur_y + CB'(1)) : cur_y;

  // Load a line or advance along it
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (load) begin
      active <= 1'b1;
    end else if (emit && last) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_x      <= head_x1;
      cur_y      <= head_y1;
      target_x   <= head_x2;
      target_y   <= head_y2;
      abs_dx     <= head_abs_dx;
      neg_abs_dy <= head_neg_abs_dy;
      step_x_neg <= head_step_x_neg;
      step_y_neg <= head_step_y_neg;
      error_term <= {2'b00, head_abs_dx} + {head_neg_abs_dy[CB], head_neg_abs_dy};
      held_color <= head_color;
    end else if (emit && !last) begin
      cur_x      <= cur_x_next;
      cur_y      <= cur_y_next;
      error_term <= error_next;
    end
  end

  // Hold the emitted pixel until the address stage takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (emit) begin
      pix_valid <= 1'b1;
    end else if (pix_ready) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pix_x     <= cur_x;
      pix_y     <= cur_y;
      pix_color <= held_color;
      pix_last  <= last;
      pix_vis   <= on_screen && (!cfg.clip_enable || in_clip);
    end
  end

endmodule

`default_nettype wire

FILE: src/clps_addr.sv
`default_nettype none

module clps_addr #(
  parameter int COORD_BITS = clps_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [clps_pkg::CFG_W-1:0]     screen_width,
  input  logic                           pix_valid,
  output logic                           pix_ready,
  input  logic [COORD_BITS-1:0]          pix_x,
  input  logic [COORD_BITS-1:0]          pix_y,
  input  logic [clps_pkg::COLOR_W-1:0]   pix_color,
  input  logic                           pix_last,
  input  logic                           pix_vis,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [COORD_BITS-1:0]          pixel_x,
  output logic [COORD_BITS-1:0]          pixel_y,
  output logic [clps_pkg::ADDR_W-1:0]    pixel_address,
  output logic [clps_pkg::COLOR_W-1:0]   pixel_color,
  output logic                           write_enable,
  output logic                           last_pixel
);
  import clps_pkg::*;

  localparam int CB = COORD_BITS;

  logic                  take;
  logic [CB+CFG_W-1:0]   row_base;
  logic [ADDR_W-1:0]     addr;

  assign pix_ready = !out_valid || out_ready;
  assign take      = pix_valid && pix_ready;

  // Form the frame-buffer address, wrapped to the address width
  assign row_base = pix_y * screen_width;
  assign addr     = ADDR_W'(row_base) + ADDR_W'(pix_x);

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pixel_x       <= pix_x;
      pixel_y       <= pix_y;
      pixel_address <= pix_vis ? addr : '0;
      pixel_color   <= pix_color;
      write_enable  <= pix_vis;
      last_pixel    <= pix_last;
    end
  end

endmodule

`default_nettype wire

FILE: src/clipped_line_pixel_stepper_top.sv
// A step request moves from its queue entry to the pixel register, then the output register.
// Throughput: one request per cycle unless out_ready stalls, set by the Bresenham update.
// A two-entry request queue sits between the front end and the stepper.
// Reset (synchronous, rst high) empties the queue and pipeline, drops any loaded line
// and returns the configuration registers to their defaults.
`default_nettype none

module clipped_line_pixel_stepper_top #(
  parameter int COORD_BITS = clps_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [clps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [clps_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              req_type,
  input  logic signed [COORD_BITS-1:0]      start_x,
  input  logic signed [COORD_BITS-1:0]      start_y,
  input  logic signed [COORD_BITS-1:0]      end_x,
  input  logic signed [COORD_BITS-1:0]      end_y,
  input  logic [clps_pkg::COLOR_W-1:0]      line_color,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [COORD_BITS-1:0]      pixel_x,
  output logic signed [COORD_BITS-1:0]      pixel_y,
  output logic [clps_pkg::ADDR_W-1:0]       pixel_address,
  output logic [clps_pkg::COLOR_W-1:0]      pixel_color,
  output logic                              write_enable,
  output logic                              last_pixel
);
  import clps_pkg::*;

  localparam int CB = COORD_BITS;

  cfg_t               cfg;

  logic               head_valid;
  logic               head_pop;
  logic               head_step;
  logic [CB-1:0]      head_x1;
  logic [CB-1:0]      head_y1;
  logic [CB-1:0]      head_x2;
  logic [CB-1:0]      head_y2;
  logic [COLOR_W-1:0] head_color;
  logic [CB-1:0]      head_abs_dx;
  logic [CB:0]        head_neg_abs_dy;
  logic               head_step_x_neg;
  logic               head_step_y_neg;

  logic               pix_valid;
  logic               pix_ready;
  logic [CB-1:0]      pix_x;
  logic [CB-1:0]      pix_y;
  logic [COLOR_W-1:0] pix_color;
  logic               pix_last;
  logic               pix_vis;

  // Write configuration registers; ignore unused indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= SCREEN_WIDTH_RST;
      cfg.screen_height <= SCREEN_HEIGHT_RST;
      cfg.clip_enable   <= 1'b0;
      cfg.clip_left     <= '0;
      cfg.clip_top      <= '0;
      cfg.clip_span_x   <= '0;
      cfg.clip_span_y   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data;
        REG_CLIP_ENABLE:   cfg.clip_enable   <= cfg_data[0];
        REG_CLIP_LEFT:     cfg.clip_left     <= cfg_data;
        REG_CLIP_TOP:      cfg.clip_top      <= cfg_data;
        REG_CLIP_SPAN_X:   cfg.clip_span_x   <= cfg_data;
        REG_CLIP_SPAN_Y:   cfg.clip_span_y   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Accept and classify requests
  clps_front #(
    .COORD_BITS(CB)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .req_type        (req_type),
    .start_x         (start_x),
    .start_y         (start_y),
    .end_x           (end_x),
    .end_y           (end_y),
    .line_color      (line_color),
    .head_valid      (head_valid),
    .head_pop        (head_pop),
    .head_step       (head_step),
    .head_x1         (head_x1),
    .head_y1         (head_y1),
    .head_x2         (head_x2),
    .head_y2         (head_y2),
    .head_color      (head_color),
    .head_abs_dx     (head_abs_dx),
    .head_neg_abs_dy (head_neg_abs_dy),
    .head_step_x_neg (head_step_x_neg),
    .head_step_y_neg (head_step_y_neg)
  );

  // Walk the line
  clps_stepper #(
    .COORD_BITS(CB)
  ) u_stepper (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .head_valid      (head_valid),
    .head_pop        (head_pop),
    .head_step       (head_step),
    .head_x1         (head_x1),
    .head_y1         (head_y1),
    .head_x2         (head_x2),
    .head_y2         (head_y2),
    .head_color      (head_color),
    .head_abs_dx     (head_abs_dx),
    .head_neg_abs_dy (head_neg_abs_dy),
    .head_step_x_neg (head_step_x_neg),
    .head_step_y_neg (head_step_y_neg),
    .pix_valid       (pix_valid),
    .pix_ready       (pix_ready),
    .pix_x           (pix_x),
    .pix_y           (pix_y),
    .pix_color       (pix_color),
    .pix_last        (pix_last),
    .pix_vis         (pix_vis)
  );

  // Address and output register
  clps_addr #(
    .COORD_BITS(CB)
  ) u_addr (
    .clk           (clk),
    .rst           (rst),
    .screen_width  (cfg.screen_width),
    .pix_valid     (pix_valid),
    .pix_ready     (pix_ready),
    .pix_x         (pix_x),
    .pix_y         (pix_y),
    .pix_color     (pix_color),
    .pix_last      (pix_last),
    .pix_vis       (pix_vis),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .pixel_address (pixel_address),
    .pixel_color   (pixel_color),
    .write_enable  (write_enable),
    .last_pixel    (last_pixel)
  );

`ifndef SYNTH
  // A stalled pixel in the stepper stage must not change
  a_pix_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_ready |=> pix_valid && $stable(pix_x) && $stable(pix_y)
                                && $stable(pix_last) && $stable(pix_vis))
    else $error("stepper pixel changed while stalled");

  // A full request queue always offers a head to the stepper
  a_queue_head: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> head_valid)
    else $error("request queue full but no head");

  // A written pixel has non-negative x and y and an x below the screen width
  a_on_screen: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_enable |-> !pixel_x[CB-1] && !pixel_y[CB-1]
      && ((CB+CFG_W)'(unsigned'(pixel_x)) < (CB+CFG_W)'(cfg.screen_width)))
    else $error("write enabled for an off-screen pixel");
`endif

endmodule

`default_nettype wire
